// ===== design/mf3_pkg.sv =====
package mf3_pkg;

  // pixel and window geometry
  localparam int PIX_W       = 8;
  localparam int WIN_SIDE    = 3;
  localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;
  localparam int POS_W       = 10;
  localparam int DIM_W       = 11;
  localparam int COUNT_LIMIT = 1024;

  // reset value of both image dimension registers
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd7;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_CELLS-1:0][PIX_W-1:0] win_t;

  // median-of-nine exchange network: each step orders (lo, hi) so lo holds the min
  localparam int MED_STEPS = 19;
  localparam int SORT_LO [MED_STEPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int SORT_HI [MED_STEPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  function automatic pix_t median9(input win_t win);
    win_t p;
    pix_t a;
    pix_t b;
    p = win;
    for (int i = 0; i < MED_STEPS; i++) begin
      a = p[SORT_LO[i]];
      b = p[SORT_HI[i]];
      if (a > b) begin
        p[SORT_LO[i]] = b;
        p[SORT_HI[i]] = a;
      end
    end
    return p[WIN_CELLS / 2];
  endfunction

endpackage

// ===== design/mf3_pixel_if.sv =====
interface mf3_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [mf3_pkg::PIX_W-1:0] pixel;
  logic                      start_of_frame;

  modport source (output valid, pixel, start_of_frame, input ready);
  modport sink   (input valid, pixel, start_of_frame, output ready);
endinterface

// ===== design/mf3_result_if.sv =====
interface mf3_result_if;
  logic                      valid;
  logic                      ready;
  logic [mf3_pkg::PIX_W-1:0] median_value;
  logic [mf3_pkg::POS_W-1:0] out_row;
  logic [mf3_pkg::POS_W-1:0] out_col;
  logic                      last_of_frame;

  modport source (output valid, median_value, out_row, out_col, last_of_frame, input ready);
  modport sink   (input valid, median_value, out_row, out_col, last_of_frame, output ready);
endinterface

// ===== design/mf3_cfg_if.sv =====
interface mf3_cfg_if;
  logic                      valid;
  logic                      ready;
  mf3_pkg::cfg_reg_t         index;
  logic [mf3_pkg::DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/median_filter_3x3.sv =====
// channel | dir | payload                                                    | transaction
// in_pix  | in  | pixel[7:0], start_of_frame                                 | valid && ready
// out_res | out | median_value[7:0], out_row[9:0], out_col[9:0], last_of_frame | valid && ready
// cfg_wr  | in  | index (image_width / image_height), data[10:0]             | valid && ready
//
// one pixel per cycle unless out_res stalls; a pixel's result is held first in the
// line store read register, then in the result register after the sorting network
// rst_n is synchronous; counters and window clear, dimensions reset to DIM_RESET; the
// line stores are not cleared: a column is rewritten before any window result uses it
// a stalled result register holds the line store stage, which in turn holds in_pix.ready
// cfg_wr.ready is always high
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  mf3_pixel_if.sink           in_pix,
  mf3_result_if.source        out_res,
  mf3_cfg_if.sink             cfg_wr
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int WMAX_I = (MAX_WIDTH < mf3_pkg::COUNT_LIMIT) ? MAX_WIDTH : mf3_pkg::COUNT_LIMIT;
  localparam logic [mf3_pkg::DIM_W-1:0] WMAX = mf3_pkg::DIM_W'(WMAX_I);
  localparam logic [mf3_pkg::DIM_W-1:0] HMAX = mf3_pkg::DIM_W'(mf3_pkg::COUNT_LIMIT);
  localparam logic [mf3_pkg::DIM_W-1:0] DIM_MIN = mf3_pkg::DIM_W'(mf3_pkg::WIN_SIDE);
  localparam logic [mf3_pkg::POS_W-1:0] EDGE = mf3_pkg::POS_W'(mf3_pkg::WIN_SIDE - 1);

  typedef struct packed {
    logic                      produce;
    logic                      last;
    logic [mf3_pkg::POS_W-1:0] row;
    logic [mf3_pkg::POS_W-1:0] col;
    mf3_pkg::pix_t             pixel;
  } stage_t;

  // configuration registers
  logic [mf3_pkg::DIM_W-1:0] image_width_r;
  logic [mf3_pkg::DIM_W-1:0] image_height_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= mf3_pkg::DIM_RESET;
      image_height_r <= mf3_pkg::DIM_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        mf3_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wr.data;
        mf3_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wr.data;
        default:                   image_width_r  <= image_width_r;
      endcase
    end
  end

  // handshake control
  logic   s1_valid_r;
  stage_t s1_r;
  logic   out_valid_r;
  logic   out_free;
  logic   s1_adv;
  logic   in_fire;

  assign out_free     = !out_valid_r || out_res.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_pix.ready = !s1_valid_r || out_free;
  assign in_fire      = in_pix.valid && in_pix.ready;

  // effective dimensions, saturated to the supported range
  logic [mf3_pkg::DIM_W-1:0] w_eff;
  logic [mf3_pkg::DIM_W-1:0] h_eff;

  always_comb begin
    if (image_width_r < DIM_MIN)   w_eff = DIM_MIN;
    else if (image_width_r > WMAX) w_eff = WMAX;
    else                           w_eff = image_width_r;
    if (image_height_r < DIM_MIN)   h_eff = DIM_MIN;
    else if (image_height_r > HMAX) h_eff = HMAX;
    else                            h_eff = image_height_r;
  end

  // raster position of the incoming pixel
  logic [mf3_pkg::POS_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [mf3_pkg::POS_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [mf3_pkg::POS_W-1:0] col_base;
  logic [mf3_pkg::POS_W-1:0] cur_col;
  logic [mf3_pkg::POS_W-1:0] cur_row;
  logic                      row_end;
  logic                      frame_end;
  logic [ADDR_W-1:0]         rd_addr;
  stage_t                    s1_nxt;

  always_comb begin
    col_base = in_pix.start_of_frame ? '0 : col_cnt_r;
    cur_row  = in_pix.start_of_frame ? '0 : row_cnt_r;
    if ({1'b0, col_base} >= WMAX) cur_col = mf3_pkg::POS_W'(WMAX - 1'b1);
    else                          cur_col = col_base;
    row_end   = {1'b0, cur_col} >= (w_eff - 1'b1);
    frame_end = row_end && ({1'b0, cur_row} >= (h_eff - 1'b1));
    rd_addr   = ADDR_W'(cur_col);
    if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = frame_end ? '0 : cur_row + 1'b1;
    end else begin
      col_cnt_nxt = cur_col + 1'b1;
      row_cnt_nxt = cur_row;
    end
    s1_nxt.produce = (cur_row >= EDGE) && (cur_col >= EDGE);
    s1_nxt.last    = frame_end;
    s1_nxt.row     = cur_row - EDGE;
    s1_nxt.col     = cur_col - EDGE;
    s1_nxt.pixel   = in_pix.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // line stage register
  logic [ADDR_W-1:0] s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r      <= s1_nxt;
      s1_addr_r <= rd_addr;
    end
  end

  // line stores: read on accept, written back when the line stage retires
  mf3_pkg::pix_t upper_mem [MAX_WIDTH];
  mf3_pkg::pix_t mid_mem   [MAX_WIDTH];
  mf3_pkg::pix_t up_rd_r;
  mf3_pkg::pix_t mid_rd_r;
  mf3_pkg::pix_t up_eff;
  mf3_pkg::pix_t mid_eff;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      upper_mem[s1_addr_r] <= mid_eff;
    end
    if (in_fire) begin
      up_rd_r <= upper_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mid_mem[s1_addr_r] <= s1_r.pixel;
    end
    if (in_fire) begin
      mid_rd_r <= mid_mem[rd_addr];
    end
  end

  // bypass when the retiring pixel writes the column just read
  logic          fwd_r;
  mf3_pkg::pix_t fwd_up_r;
  mf3_pkg::pix_t fwd_mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_adv && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_r.pixel;
    end
  end

  assign up_eff  = fwd_r ? fwd_up_r  : up_rd_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_rd_r;

  // window shift: every row moves left, new column enters on the right
  mf3_pkg::win_t window_r, window_nxt;
  mf3_pkg::pix_t col_new [mf3_pkg::WIN_SIDE];

  always_comb begin
    col_new[0] = up_eff;
    col_new[1] = mid_eff;
    col_new[2] = s1_r.pixel;
    for (int k = 0; k < mf3_pkg::WIN_SIDE; k++) begin
      for (int x = 0; x < mf3_pkg::WIN_SIDE - 1; x++) begin
        window_nxt[k * mf3_pkg::WIN_SIDE + x] = window_r[k * mf3_pkg::WIN_SIDE + x + 1];
      end
      window_nxt[k * mf3_pkg::WIN_SIDE + mf3_pkg::WIN_SIDE - 1] = col_new[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_adv) begin
      window_r <= window_nxt;
    end
  end

  // result register
  mf3_pkg::pix_t             med_r;
  logic [mf3_pkg::POS_W-1:0] res_row_r;
  logic [mf3_pkg::POS_W-1:0] res_col_r;
  logic                      res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      med_r      <= mf3_pkg::median9(window_nxt);
      res_row_r  <= s1_r.row;
      res_col_r  <= s1_r.col;
      res_last_r <= s1_r.last;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.median_value  = med_r;
  assign out_res.out_row       = res_row_r;
  assign out_res.out_col       = res_col_r;
  assign out_res.last_of_frame = res_last_r;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_pix.ready)
    else $error("input taken while line stage is stalled");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_r.produce))
    else $error("result appeared without a retiring window");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_cnt_r} < WMAX)
    else $error("column counter beyond line store");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.last) |-> s1_r.produce)
    else $error("frame end without a window result");

endmodule
